// ===== sv/fsbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Full-search block matcher package
// Shared constants, codes and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package fsbm_pkg;

   localparam int MAX_BLOCK_DEF = 16;
   localparam int MAX_RANGE_DEF = 16;

   localparam int OP_W       = 2;
   localparam int PIX_W      = 8;
   localparam int COORD_W    = 8;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 12;
   localparam int BLK_CFG_W  = 5;
   localparam int FRM_W      = 12;
   localparam int SAD_OUT_W  = 16;
   localparam int MV_W       = 8;
   localparam int POS_W      = 16;

   localparam logic [BLK_CFG_W-1:0] BLOCK_WIDTH_RST  = 5'd16;
   localparam logic [BLK_CFG_W-1:0] BLOCK_HEIGHT_RST = 5'd16;
   localparam logic [BLK_CFG_W-1:0] SEARCH_RANGE_RST = 5'd16;
   localparam logic [FRM_W-1:0]     FRAME_WIDTH_RST  = 12'd1920;
   localparam logic [FRM_W-1:0]     FRAME_HEIGHT_RST = 12'd1080;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_CUR = 2'd0,
      OP_LOAD_WIN = 2'd1,
      OP_SEARCH   = 2'd2,
      OP_NOP      = 2'd3
   } op_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_BLOCK_WIDTH  = 3'd0,
      REG_BLOCK_HEIGHT = 3'd1,
      REG_SEARCH_RANGE = 3'd2,
      REG_FRAME_WIDTH  = 3'd3,
      REG_FRAME_HEIGHT = 3'd4
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_READ,
      ST_ACC,
      ST_SCORE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_cur;
      logic load_win;
      logic init;
      logic cand_start;
      logic cand_adv;
      logic rd;
      logic acc;
      logic score;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic in_frame;
      logic last_cand;
      logic last_pix;
      logic out_free;
   } sts_type;

endpackage

// ===== sv/fsbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Block matcher controller
// Sequences loads, the candidate scan, the pixel loop and the result hand-off.
// ----------------------------------------------------------------------------
module fsbm_ctrl import fsbm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_operation,
   output logic            req_ready,
   output cmd_type         cmd,
   input  sts_type         sts
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_operation == OP_SEARCH) state_in = ST_CAND;
         end
         ST_CAND: begin
            if (sts.in_frame) state_in = ST_READ;
            else if (sts.last_cand) state_in = ST_OUT;
         end
         ST_READ: state_in = ST_ACC;
         ST_ACC: begin
            if (sts.last_pix) state_in = ST_SCORE;
            else state_in = ST_READ;
         end
         ST_SCORE: begin
            if (sts.last_cand) state_in = ST_OUT;
            else state_in = ST_CAND;
         end
         ST_OUT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_cur = req_valid && req_operation == OP_LOAD_CUR;
            cmd.load_win = req_valid && req_operation == OP_LOAD_WIN;
            cmd.init     = req_valid && req_operation == OP_SEARCH;
         end
         ST_CAND: begin
            cmd.cand_start = sts.in_frame;
            cmd.cand_adv   = !sts.in_frame;
         end
         ST_READ:  cmd.rd = 1'b1;
         ST_ACC:   cmd.acc = 1'b1;
         ST_SCORE: begin
            cmd.score    = 1'b1;
            cmd.cand_adv = 1'b1;
         end
         ST_OUT:   cmd.out_load = sts.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== sv/fsbm_dp.sv =====
// ----------------------------------------------------------------------------
// Block matcher datapath
// Pixel stores, configuration registers, scan counters, SAD accumulator and
// the result register.
// ----------------------------------------------------------------------------
module fsbm_dp import fsbm_pkg::*; #(
   parameter int MAX_BLOCK = MAX_BLOCK_DEF,
   parameter int MAX_RANGE = MAX_RANGE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output sts_type                     sts,
   input  logic [PIX_W-1:0]            req_pixel,
   input  logic [COORD_W-1:0]          req_block_col,
   input  logic [COORD_W-1:0]          req_block_row,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CFG_IDX_W-1:0]        csr_index,
   input  logic [CFG_DATA_W-1:0]       csr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [SAD_OUT_W-1:0]        rsp_best_sad,
   output logic signed [MV_W-1:0]      rsp_mv_x,
   output logic signed [MV_W-1:0]      rsp_mv_y
);

   localparam int BW_W      = $clog2(MAX_BLOCK + 1);
   localparam int SR_W      = $clog2(MAX_RANGE + 1);
   localparam int OFF_W     = $clog2(2 * MAX_RANGE + 1);
   localparam int XY_W      = $clog2(MAX_BLOCK);
   localparam int CUR_DEPTH = MAX_BLOCK * MAX_BLOCK;
   localparam int CA_W      = $clog2(CUR_DEPTH);
   localparam int WIN_SIDE  = MAX_BLOCK + 2 * MAX_RANGE;
   localparam int WIN_DEPTH = WIN_SIDE * WIN_SIDE;
   localparam int WA_W      = $clog2(WIN_DEPTH);
   localparam int WW_W      = $clog2(WIN_SIDE + 1);
   localparam int SAD_W     = $clog2(CUR_DEPTH * 255 + 1);
   localparam int DXW_W     = MV_W + OFF_W + 1;

   logic [PIX_W-1:0] cur_mem_ff [CUR_DEPTH];
   logic [PIX_W-1:0] win_mem_ff [WIN_DEPTH];
   logic [PIX_W-1:0] cur_q_ff, win_q_ff;

   logic [BLK_CFG_W-1:0] block_width_ff, block_height_ff, search_range_ff;
   logic [FRM_W-1:0]     frame_width_ff, frame_height_ff;

   logic [CA_W-1:0]   cur_idx_ff, cur_idx_in;
   logic [WA_W-1:0]   win_idx_ff, win_idx_in;
   logic [BW_W-1:0]   bw_ff, bw_in, bh_ff, bh_in;
   logic [SR_W-1:0]   sr_ff, sr_in;
   logic [WW_W-1:0]   ww_ff, ww_in;
   logic [POS_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [OFF_W-1:0]  dxo_ff, dxo_in, dyo_ff, dyo_in;
   logic [WA_W-1:0]   cand_row_ff, cand_row_in;
   logic [XY_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [CA_W-1:0]   cur_addr_ff, cur_addr_in;
   logic [WA_W-1:0]   win_row_ff, win_row_in;
   logic [SAD_W-1:0]  sad_ff, sad_in, best_ff, best_in;
   logic              found_ff, found_in;
   logic [OFF_W-1:0]  bdxo_ff, bdxo_in, bdyo_ff, bdyo_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [SAD_OUT_W-1:0]  rsp_sad_ff, rsp_sad_in;
   logic [MV_W-1:0]       rsp_mvx_ff, rsp_mvx_in, rsp_mvy_ff, rsp_mvy_in;

   logic [BW_W-1:0]   bw_clamp, bh_clamp;
   logic [SR_W-1:0]   sr_clamp;
   logic [OFF_W-1:0]  span;
   logic [POS_W-1:0]  rx_p, ry_p;
   logic [WA_W-1:0]   win_addr;
   logic [PIX_W-1:0]  diff;
   logic              x_last;
   logic signed [OFF_W:0] dx_s, dy_s;
   logic signed [DXW_W-1:0] dx_w, dy_w;

   assign csr_ready = 1'b1;

   // Out-of-range block sizes and search ranges act as the nearest legal value.
   always_comb begin
      if (block_width_ff == '0) bw_clamp = BW_W'(1);
      else if (int'(block_width_ff) > MAX_BLOCK) bw_clamp = BW_W'(MAX_BLOCK);
      else bw_clamp = BW_W'(block_width_ff);
      if (block_height_ff == '0) bh_clamp = BW_W'(1);
      else if (int'(block_height_ff) > MAX_BLOCK) bh_clamp = BW_W'(MAX_BLOCK);
      else bh_clamp = BW_W'(block_height_ff);
      if (int'(search_range_ff) > MAX_RANGE) sr_clamp = SR_W'(MAX_RANGE);
      else sr_clamp = SR_W'(search_range_ff);
   end

   assign span     = OFF_W'(sr_ff) << 1;
   assign rx_p     = cx_ff + POS_W'(dxo_ff);
   assign ry_p     = cy_ff + POS_W'(dyo_ff);
   assign win_addr = win_row_ff + WA_W'(x_ff);
   assign diff     = (cur_q_ff > win_q_ff) ? cur_q_ff - win_q_ff : win_q_ff - cur_q_ff;
   assign x_last   = x_ff == XY_W'(bw_ff - BW_W'(1));

   // The candidate's block must lie wholly inside the frame; the offset form
   // keeps every term unsigned.
   assign sts.in_frame = (rx_p >= POS_W'(sr_ff)) && (ry_p >= POS_W'(sr_ff)) &&
                         (rx_p + POS_W'(bw_ff) <= POS_W'(frame_width_ff) + POS_W'(sr_ff)) &&
                         (ry_p + POS_W'(bh_ff) <= POS_W'(frame_height_ff) + POS_W'(sr_ff));
   assign sts.last_cand = (dxo_ff == span) && (dyo_ff == span);
   assign sts.last_pix  = x_last && (y_ff == XY_W'(bh_ff - BW_W'(1)));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign dx_s = signed'((OFF_W+1)'(bdxo_ff)) - signed'((OFF_W+1)'(sr_ff));
   assign dy_s = signed'((OFF_W+1)'(bdyo_ff)) - signed'((OFF_W+1)'(sr_ff));
   assign dx_w = DXW_W'(dx_s);
   assign dy_w = DXW_W'(dy_s);

   always_comb begin
      cur_idx_in  = cur_idx_ff;
      win_idx_in  = win_idx_ff;
      bw_in       = bw_ff;
      bh_in       = bh_ff;
      sr_in       = sr_ff;
      ww_in       = ww_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      dxo_in      = dxo_ff;
      dyo_in      = dyo_ff;
      cand_row_in = cand_row_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      cur_addr_in = cur_addr_ff;
      win_row_in  = win_row_ff;
      sad_in      = sad_ff;
      best_in     = best_ff;
      found_in    = found_ff;
      bdxo_in     = bdxo_ff;
      bdyo_in     = bdyo_ff;

      if (cmd.load_cur) begin
         if (cur_idx_ff == CA_W'(CUR_DEPTH - 1)) cur_idx_in = '0;
         else cur_idx_in = cur_idx_ff + CA_W'(1);
      end
      if (cmd.load_win) begin
         if (win_idx_ff == WA_W'(WIN_DEPTH - 1)) win_idx_in = '0;
         else win_idx_in = win_idx_ff + WA_W'(1);
      end
      if (cmd.init) begin
         cur_idx_in  = '0;
         win_idx_in  = '0;
         bw_in       = bw_clamp;
         bh_in       = bh_clamp;
         sr_in       = sr_clamp;
         ww_in       = WW_W'(bw_clamp) + (WW_W'(sr_clamp) << 1);
         cx_in       = POS_W'(POS_W'(req_block_col) * POS_W'(bw_clamp));
         cy_in       = POS_W'(POS_W'(req_block_row) * POS_W'(bh_clamp));
         dxo_in      = '0;
         dyo_in      = '0;
         cand_row_in = '0;
         found_in    = 1'b0;
      end
      if (cmd.cand_start) begin
         x_in        = '0;
         y_in        = '0;
         cur_addr_in = '0;
         win_row_in  = cand_row_ff + WA_W'(dxo_ff);
         sad_in      = '0;
      end
      if (cmd.acc) begin
         sad_in      = sad_ff + SAD_W'(diff);
         cur_addr_in = cur_addr_ff + CA_W'(1);
         if (x_last) begin
            x_in       = '0;
            y_in       = y_ff + XY_W'(1);
            win_row_in = win_row_ff + WA_W'(ww_ff);
         end else begin
            x_in = x_ff + XY_W'(1);
         end
      end
      if (cmd.score) begin
         if (!found_ff || sad_ff < best_ff) begin
            found_in = 1'b1;
            best_in  = sad_ff;
            bdxo_in  = dxo_ff;
            bdyo_in  = dyo_ff;
         end
      end
      if (cmd.cand_adv) begin
         if (dxo_ff == span) begin
            dxo_in      = '0;
            dyo_in      = dyo_ff + OFF_W'(1);
            cand_row_in = cand_row_ff + WA_W'(ww_ff);
         end else begin
            dxo_in = dxo_ff + OFF_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_sad_in   = rsp_sad_ff;
      rsp_mvx_in   = rsp_mvx_ff;
      rsp_mvy_in   = rsp_mvy_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
         if (found_ff) begin
            rsp_sad_in = SAD_OUT_W'(best_ff);
            rsp_mvx_in = MV_W'(dx_w <<< 2);
            rsp_mvy_in = MV_W'(dy_w <<< 2);
         end else begin
            rsp_sad_in = '1;
            rsp_mvx_in = '0;
            rsp_mvy_in = '0;
         end
      end
   end

   // Pixel stores: one write port for loading, one registered read per store.
   always_ff @(posedge clock) begin
      if (cmd.load_cur) cur_mem_ff[cur_idx_ff] <= req_pixel;
      if (cmd.load_win) win_mem_ff[win_idx_ff] <= req_pixel;
      if (cmd.rd) begin
         cur_q_ff <= cur_mem_ff[cur_addr_ff];
         win_q_ff <= win_mem_ff[win_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_width_ff  <= BLOCK_WIDTH_RST;
         block_height_ff <= BLOCK_HEIGHT_RST;
         search_range_ff <= SEARCH_RANGE_RST;
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BLOCK_WIDTH:  block_width_ff  <= csr_data[BLK_CFG_W-1:0];
            REG_BLOCK_HEIGHT: block_height_ff <= csr_data[BLK_CFG_W-1:0];
            REG_SEARCH_RANGE: search_range_ff <= csr_data[BLK_CFG_W-1:0];
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data[FRM_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data[FRM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_idx_ff   <= '0;
         win_idx_ff   <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_idx_ff   <= cur_idx_in;
         win_idx_ff   <= win_idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bw_ff       <= bw_in;
      bh_ff       <= bh_in;
      sr_ff       <= sr_in;
      ww_ff       <= ww_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      dxo_ff      <= dxo_in;
      dyo_ff      <= dyo_in;
      cand_row_ff <= cand_row_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      cur_addr_ff <= cur_addr_in;
      win_row_ff  <= win_row_in;
      sad_ff      <= sad_in;
      best_ff     <= best_in;
      bdxo_ff     <= bdxo_in;
      bdyo_ff     <= bdyo_in;
      rsp_found_ff <= rsp_found_in;
      rsp_sad_ff   <= rsp_sad_in;
      rsp_mvx_ff   <= rsp_mvx_in;
      rsp_mvy_ff   <= rsp_mvy_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_best_sad = rsp_sad_ff;
   assign rsp_mv_x     = rsp_mvx_ff;
   assign rsp_mv_y     = rsp_mvy_ff;

endmodule

// ===== sv/full_search_block_matcher_core.sv =====
// ----------------------------------------------------------------------------
// Full-search block matcher core
// Integer-pel full-search motion estimation by sum of absolute differences.
// ----------------------------------------------------------------------------
// Load requests (current block pixel, window pixel) are taken one per cycle
// while the controller is idle. A search request scans every displacement row
// by row: each candidate first gets a frame bounds check, and a candidate
// inside the frame then runs a pixel loop that alternates a read state and an
// accumulate state for each pixel pair, since each pixel store has a single
// read port, followed by a scoring state. The result is then handed to the
// output register. A finished result may wait in the output register while
// new load requests arrive.
module full_search_block_matcher_core import fsbm_pkg::*; #(
   parameter int MAX_BLOCK = MAX_BLOCK_DEF,
   parameter int MAX_RANGE = MAX_RANGE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [PIX_W-1:0]       req_pixel,
   input  logic [COORD_W-1:0]     req_block_col,
   input  logic [COORD_W-1:0]     req_block_row,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_IDX_W-1:0]   csr_index,
   input  logic [CFG_DATA_W-1:0]  csr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_found,
   output logic [SAD_OUT_W-1:0]   rsp_best_sad,
   output logic signed [MV_W-1:0] rsp_mv_x,
   output logic signed [MV_W-1:0] rsp_mv_y
);

   cmd_type cmd;
   sts_type sts;

   fsbm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .cmd           (cmd),
      .sts           (sts)
   );

   fsbm_dp #(
      .MAX_BLOCK (MAX_BLOCK),
      .MAX_RANGE (MAX_RANGE)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_pixel     (req_pixel),
      .req_block_col (req_block_col),
      .req_block_row (req_block_row),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_found     (rsp_found),
      .rsp_best_sad  (rsp_best_sad),
      .rsp_mv_x      (rsp_mv_x),
      .rsp_mv_y      (rsp_mv_y)
   );

endmodule

// ===== sv/fsbm_chk.sv =====
// ----------------------------------------------------------------------------
// Block matcher port checker
// Watches the top-level ports for result and sequencing slips.
// ----------------------------------------------------------------------------
module fsbm_chk import fsbm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [OP_W-1:0]        req_operation,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_found,
   input logic [SAD_OUT_W-1:0]   rsp_best_sad,
   input logic signed [MV_W-1:0] rsp_mv_x,
   input logic signed [MV_W-1:0] rsp_mv_y
);

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_best_sad) && $stable(rsp_mv_x) && $stable(rsp_mv_y))
      else $error("stalled result changed");

   // An empty search reports the all-ones SAD and a zero vector.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_best_sad == '1 && rsp_mv_x == '0 && rsp_mv_y == '0)
      else $error("empty search result malformed");

   // Vectors are whole pixels in quarter-pel units.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_mv_x[1:0] == 2'b00 && rsp_mv_y[1:0] == 2'b00)
      else $error("vector not on integer pel");

   // Once a search request is taken, no request is taken the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_SEARCH |=> !req_ready)
      else $error("request taken during search");

endmodule

bind full_search_block_matcher_core fsbm_chk u_fsbm_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_found     (rsp_found),
   .rsp_best_sad  (rsp_best_sad),
   .rsp_mv_x      (rsp_mv_x),
   .rsp_mv_y      (rsp_mv_y)
);
